@@ sv/nts_pkg.sv @@
// Shared types, widths and codes for the nearest timestamp frame seek block.
package nts_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 4096;
  localparam int STAMP_BITS  = 48;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field and register widths.
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 3;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CMP_W     = (STAMP_BITS > CFG_W) ? STAMP_BITS : CFG_W;

  // Word kinds.
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FAR     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_OUTSIDE = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_UNDER   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd4;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOL   = 1'd1;
  localparam logic [CFG_W-1:0]     TIME_WINDOW_RST = 32'd1000;
  localparam logic [CFG_W-1:0]     MATCH_TOL_RST   = 32'd100;

  // Source of the table read address.
  typedef enum logic [1:0] {
    ADDR_FIRST,
    ADDR_LAST,
    ADDR_MID,
    ADDR_NEXT
  } nts_addr_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                latch_in;
    logic                do_append;
    logic                do_clear;
    logic                set_res;
    logic [STATUS_W-1:0] res_status;
    logic                rd_en;
    nts_addr_sel_e       rd_sel;
    logic                cap_first;
    logic                cap_last;
    logic                step;
    logic                calc_diff;
    logic                calc_pick;
    logic                finish;
    logic                load_out;
  } nts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              lt_two;
    logic              full;
    logic              win_out;
    logic              init_more;
    logic              next_more;
  } nts_stat_t;

endpackage

@@ sv/nts_if.sv @@
// Valid/ready channel interfaces for input words and result words.
interface nts_in_if;
  logic                                valid;
  logic                                ready;
  logic [nts_pkg::KIND_W-1:0]          kind;
  logic [nts_pkg::STAMP_BITS-1:0]      stamp_value;

  modport source (output valid, kind, stamp_value, input ready);
  modport sink   (input valid, kind, stamp_value, output ready);
endinterface

interface nts_out_if;
  logic                           valid;
  logic                           ready;
  logic [nts_pkg::STATUS_W-1:0]   status;
  logic [nts_pkg::IDX_W-1:0]      frame_index;
  logic [nts_pkg::IDX_W-1:0]      frames_to_advance;
  logic [nts_pkg::IDX_W-1:0]      frame_position;

  modport source (output valid, status, frame_index, frames_to_advance, frame_position,
                  input ready);
  modport sink   (input valid, status, frame_index, frames_to_advance, frame_position,
                  output ready);
endinterface

@@ sv/nts_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module nts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/nts_ctrl.sv @@
// Controller state machine that sequences table loads, clears and searches.
module nts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  nts_pkg::nts_stat_t stat_i,
  output nts_pkg::nts_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EXEC    = 4'd1;
  localparam logic [3:0] S_W_FIRST = 4'd2;
  localparam logic [3:0] S_W_LAST  = 4'd3;
  localparam logic [3:0] S_CHECK   = 4'd4;
  localparam logic [3:0] S_W_MID   = 4'd5;
  localparam logic [3:0] S_DIFF    = 4'd6;
  localparam logic [3:0] S_PICK    = 4'd7;
  localparam logic [3:0] S_FINISH  = 4'd8;
  localparam logic [3:0] S_EMIT    = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_EMIT;
        unique case (stat_i.kind)
          nts_pkg::KIND_APPEND: begin
            cmd_o.set_res = 1'b1;
            if (stat_i.full) begin
              cmd_o.res_status = nts_pkg::STAT_FULL;
            end else begin
              cmd_o.do_append  = 1'b1;
              cmd_o.res_status = nts_pkg::STAT_OK;
            end
          end
          nts_pkg::KIND_QUERY: begin
            if (stat_i.lt_two) begin
              cmd_o.set_res    = 1'b1;
              cmd_o.res_status = nts_pkg::STAT_UNDER;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = nts_pkg::ADDR_FIRST;
              state_d      = S_W_FIRST;
            end
          end
          nts_pkg::KIND_CLEAR: begin
            cmd_o.do_clear   = 1'b1;
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = nts_pkg::STAT_OK;
          end
          default: begin
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = nts_pkg::STAT_OK;
          end
        endcase
      end
      S_W_FIRST: begin
        cmd_o.cap_first = 1'b1;
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = nts_pkg::ADDR_LAST;
        state_d         = S_W_LAST;
      end
      S_W_LAST: begin
        cmd_o.cap_last = 1'b1;
        state_d        = S_CHECK;
      end
      S_CHECK: begin
        priority if (stat_i.win_out) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = nts_pkg::STAT_OUTSIDE;
          state_d          = S_EMIT;
        end else if (stat_i.init_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = nts_pkg::ADDR_MID;
          state_d      = S_W_MID;
        end else begin
          state_d = S_DIFF;
        end
      end
      S_W_MID: begin
        // One bisection step per cycle: the next probe issues as this one lands.
        cmd_o.step = 1'b1;
        if (stat_i.next_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = nts_pkg::ADDR_NEXT;
        end else begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.calc_diff = 1'b1;
        state_d         = S_PICK;
      end
      S_PICK: begin
        cmd_o.calc_pick = 1'b1;
        state_d         = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ sv/nts_datapath.sv @@
// Datapath: timestamp table, search bounds, distance compare and frame position.
module nts_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  nts_pkg::nts_cmd_t                cmd_i,
  output nts_pkg::nts_stat_t               stat_o,
  input  logic [nts_pkg::KIND_W-1:0]       in_kind_i,
  input  logic [nts_pkg::STAMP_BITS-1:0]   in_stamp_i,
  input  logic                             cfg_we_i,
  input  logic [nts_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [nts_pkg::CFG_W-1:0]        cfg_data_i,
  output logic [nts_pkg::STATUS_W-1:0]     out_status_o,
  output logic [nts_pkg::IDX_W-1:0]        out_frame_index_o,
  output logic [nts_pkg::IDX_W-1:0]        out_frames_to_advance_o,
  output logic [nts_pkg::IDX_W-1:0]        out_frame_position_o
);

  localparam int IW = nts_pkg::IDX_W;
  localparam int CW = nts_pkg::CNT_W;
  localparam int SW = nts_pkg::STAMP_BITS;
  localparam int MW = nts_pkg::CMP_W;

  // Control state.
  logic [CW-1:0]              count_q;
  logic [IW-1:0]              frame_q;
  logic [nts_pkg::CFG_W-1:0]  time_window_q;
  logic [nts_pkg::CFG_W-1:0]  match_tol_q;

  // Payload registers.
  logic [nts_pkg::KIND_W-1:0]   kind_q;
  logic [SW-1:0]                t_q;
  logic [IW-1:0]                lo_q, hi_q, mid_q, pick_q;
  logic [SW-1:0]                lo_val_q, hi_val_q, dl_q, dr_q, dist_q;
  logic [nts_pkg::STATUS_W-1:0] res_status_q, out_status_q;
  logic [IW-1:0]                res_idx_q, res_adv_q;
  logic [IW-1:0]                out_idx_q, out_adv_q, out_pos_q;

  logic [CW-1:0]  count_m1;
  logic [IW-1:0]  last_idx;
  logic [IW:0]    cur_sum, next_sum;
  logic [IW-1:0]  cur_mid, next_mid;
  logic           cur_more, next_more;
  logic [IW-1:0]  rd_addr;
  logic [SW-1:0]  rdata;
  logic           probe_gt, probe_lt;
  logic [IW-1:0]  lo_n, hi_n;
  logic [SW-1:0]  lo_val_n, hi_val_n;
  logic           below_out, above_out;
  logic           far;
  logic           moves;
  logic [IW-1:0]  adv;

  // Table storage.
  nts_ram #(
    .WIDTH (SW),
    .DEPTH (nts_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.do_append),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (t_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // Bound arithmetic for the current and the next bisection step.
  assign count_m1  = count_q - CW'(1);
  assign last_idx  = count_m1[IW-1:0];
  assign cur_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign cur_mid   = cur_sum[IW:1];
  assign cur_more  = ({1'b0, lo_q} + (IW + 1)'(1)) < {1'b0, hi_q};

  assign probe_gt  = rdata > t_q;
  assign probe_lt  = rdata < t_q;
  assign lo_n      = probe_gt ? lo_q : mid_q;
  assign hi_n      = probe_lt ? hi_q : mid_q;
  assign lo_val_n  = probe_gt ? lo_val_q : rdata;
  assign hi_val_n  = probe_lt ? hi_val_q : rdata;
  assign next_sum  = {1'b0, lo_n} + {1'b0, hi_n};
  assign next_mid  = next_sum[IW:1];
  assign next_more = ({1'b0, lo_n} + (IW + 1)'(1)) < {1'b0, hi_n};

  // Read address selection.
  always_comb begin
    unique case (cmd_i.rd_sel)
      nts_pkg::ADDR_FIRST: rd_addr = '0;
      nts_pkg::ADDR_LAST:  rd_addr = last_idx;
      nts_pkg::ADDR_MID:   rd_addr = cur_mid;
      nts_pkg::ADDR_NEXT:  rd_addr = next_mid;
      default:             rd_addr = '0;
    endcase
  end

  // Window test against the widened first and last entries.
  assign below_out = (t_q < lo_val_q) && (MW'(lo_val_q - t_q) > MW'(time_window_q));
  assign above_out = (t_q > hi_val_q) && (MW'(t_q - hi_val_q) > MW'(time_window_q));

  // Tolerance flag and forward-only frame move.
  assign far   = MW'(dist_q) > MW'(match_tol_q);
  assign moves = pick_q > frame_q;
  assign adv   = pick_q - frame_q;

  // Status back to the controller.
  always_comb begin
    stat_o           = '0;
    stat_o.kind      = kind_q;
    stat_o.lt_two    = count_q < CW'(2);
    stat_o.full      = count_q >= CW'(nts_pkg::TABLE_DEPTH);
    stat_o.win_out   = below_out || above_out;
    stat_o.init_more = cur_more;
    stat_o.next_more = next_more;
  end

  // Entry count, frame position and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      frame_q       <= '0;
      time_window_q <= nts_pkg::TIME_WINDOW_RST;
      match_tol_q   <= nts_pkg::MATCH_TOL_RST;
    end else begin
      if (cmd_i.do_clear) begin
        count_q <= '0;
        frame_q <= '0;
      end else begin
        if (cmd_i.do_append) begin
          count_q <= count_q + CW'(1);
        end
        if (cmd_i.finish && moves) begin
          frame_q <= pick_q;
        end
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          nts_pkg::CFG_TIME_WINDOW: time_window_q <= cfg_data_i;
          nts_pkg::CFG_MATCH_TOL:   match_tol_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Input word, search bounds, distances and result staging.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      kind_q <= in_kind_i;
      t_q    <= in_stamp_i;
    end
    if (cmd_i.rd_en) begin
      mid_q <= rd_addr;
    end
    if (cmd_i.cap_first) begin
      lo_val_q <= rdata;
    end
    if (cmd_i.cap_last) begin
      hi_val_q <= rdata;
      lo_q     <= '0;
      hi_q     <= last_idx;
    end
    if (cmd_i.step) begin
      lo_q     <= lo_n;
      hi_q     <= hi_n;
      lo_val_q <= lo_val_n;
      hi_val_q <= hi_val_n;
    end
    if (cmd_i.calc_diff) begin
      dl_q <= (lo_val_q > t_q) ? (lo_val_q - t_q) : (t_q - lo_val_q);
      dr_q <= (hi_val_q > t_q) ? (hi_val_q - t_q) : (t_q - hi_val_q);
    end
    if (cmd_i.calc_pick) begin
      // The left entry wins a tie.
      pick_q <= (dl_q > dr_q) ? hi_q : lo_q;
      dist_q <= (dl_q > dr_q) ? dr_q : dl_q;
    end
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_status;
      res_idx_q    <= '0;
      res_adv_q    <= '0;
    end
    if (cmd_i.finish) begin
      res_status_q <= far ? nts_pkg::STAT_FAR : nts_pkg::STAT_OK;
      res_idx_q    <= pick_q;
      res_adv_q    <= moves ? adv : '0;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_idx_q    <= res_idx_q;
      out_adv_q    <= res_adv_q;
      out_pos_q    <= frame_q;
    end
  end

  assign out_status_o            = out_status_q;
  assign out_frame_index_o       = out_idx_q;
  assign out_frames_to_advance_o = out_adv_q;
  assign out_frame_position_o    = out_pos_q;

endmodule

@@ sv/nearest_timestamp_frame_seek_core.sv @@
// Top level of the nearest timestamp frame seek block.
//
//   Channel  Dir  Handshake    Payload
//   in_ch_i  in   valid/ready  kind, stamp_value
//   out_ch_o out  valid/ready  status, frame_index, frames_to_advance, frame_position
//   cfg      in   cfg_we_i     cfg_idx_i, cfg_data_i
//
// A word holds the block from its accept cycle until its result is loaded.
// Append, clear and unused words pass through accept, execute and result load.
// A query passes through accept, execute, first and last entry reads, window check,
// s bisection steps, distance, pick and finish before its result load, where s is at
// most ceil(log2(entry_count - 1)) and fewer on an exact hit; each step is one RAM read.
// Reset clears entry count and frame position and presets config; no clearing pass.
// A new word is accepted while a result waits in the output register; its own
// result then stalls in the last state until the receiver takes the waiting one.
module nearest_timestamp_frame_seek_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  nts_in_if.sink                        in_ch_i,
  nts_out_if.source                     out_ch_o,
  input  logic                          cfg_we_i,
  input  logic [nts_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [nts_pkg::CFG_W-1:0]     cfg_data_i
);

  nts_pkg::nts_cmd_t  cmd;
  nts_pkg::nts_stat_t stat;

  // Sequencing.
  nts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .in_ready_o  (in_ch_i.ready),
    .out_valid_o (out_ch_o.valid),
    .out_ready_i (out_ch_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Storage and arithmetic.
  nts_datapath u_datapath (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cmd_i                   (cmd),
    .stat_o                  (stat),
    .in_kind_i               (in_ch_i.kind),
    .in_stamp_i              (in_ch_i.stamp_value),
    .cfg_we_i                (cfg_we_i),
    .cfg_idx_i               (cfg_idx_i),
    .cfg_data_i              (cfg_data_i),
    .out_status_o            (out_ch_o.status),
    .out_frame_index_o       (out_ch_o.frame_index),
    .out_frames_to_advance_o (out_ch_o.frames_to_advance),
    .out_frame_position_o    (out_ch_o.frame_position)
  );

endmodule
